// File: hdl/pra_pkg.sv
// pra_pkg: shared types, status codes and defaults for the page range allocator.
// No dependencies.
package pra_pkg;
  localparam int unsigned MaxBlocksDefault = 64;
  localparam int unsigned PageBitsDefault  = 20;

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_NO_SPACE      = 2'd1,
    ST_DOUBLE_FREE   = 2'd2,
    ST_NOT_ALLOCATED = 2'd3
  } status_t;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_t;

  typedef enum logic {
    CFG_START = 1'b0,
    CFG_END   = 1'b1
  } cfg_index_t;
endpackage

// File: hdl/pra_front.sv
// pra_front: input stage; accepts items and queues them for the back end.
// Depends on pra_pkg.
module pra_front #(
  parameter int unsigned PAGE_BITS = pra_pkg::PageBitsDefault
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_action,
  input  logic [PAGE_BITS-1:0] in_request_pages,
  input  logic [PAGE_BITS-1:0] in_free_page,
  output logic                 q_valid,
  input  logic                 q_take,
  output logic                 q_action,
  output logic [PAGE_BITS-1:0] q_arg
);
  import pra_pkg::*;

  // Two-entry queue
  logic [1:0]           vld_r;
  logic [1:0]           vld_nxt;
  logic [1:0]           act_r;
  logic [PAGE_BITS-1:0] arg_r [2];
  logic                 wp_r, rp_r;
  logic                 push;

  assign in_stall = vld_r[wp_r];
  assign push     = in_valid && !in_stall;
  assign q_valid  = vld_r[rp_r];
  assign q_action = act_r[rp_r];
  assign q_arg    = arg_r[rp_r];

  always_comb begin
    vld_nxt = vld_r;
    if (q_take && q_valid) vld_nxt[rp_r] = 1'b0;
    if (push) vld_nxt[wp_r] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      if (q_take && q_valid) begin
        rp_r <= ~rp_r;
      end
      if (push) begin
        wp_r <= ~wp_r;
      end
    end
    if (push) begin
      act_r[wp_r] <= in_action;
      // classify: keep only the argument the action needs
      arg_r[wp_r] <= (action_t'(in_action) == ACT_FREE) ? in_free_page : in_request_pages;
    end
  end
endmodule

// File: hdl/pra_back.sv
// pra_back: block table and search sequencer carrying out alloc and free.
// Depends on pra_pkg.
module pra_back #(
  parameter int unsigned MAX_BLOCKS = pra_pkg::MaxBlocksDefault,
  parameter int unsigned PAGE_BITS  = pra_pkg::PageBitsDefault
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic                 cfg_index,
  input  logic [PAGE_BITS-1:0] cfg_data,
  input  logic                 q_valid,
  output logic                 q_take,
  input  logic                 q_action,
  input  logic [PAGE_BITS-1:0] q_arg,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_status,
  output logic [PAGE_BITS-1:0] out_result_page
);
  import pra_pkg::*;

  localparam int unsigned IW = $clog2(MAX_BLOCKS);
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);

  typedef enum logic [2:0] {S_IDLE, S_RD, S_CHK, S_OUT} state_t;

  logic [PAGE_BITS-1:0] base_mem [MAX_BLOCKS];
  logic [PAGE_BITS-1:0] size_mem [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] used_r;

  state_t               state_r;
  logic [CW-1:0]        count_r;
  logic [PAGE_BITS-1:0] end_r, nfp_r;
  logic                 act_r;
  logic [PAGE_BITS-1:0] arg_r;
  logic [CW-1:0]        idx_r;
  logic [PAGE_BITS-1:0] rd_base_r, rd_size_r;
  logic                 ov_r;
  logic [1:0]           st_r;
  logic [PAGE_BITS-1:0] pg_r;
  logic [PAGE_BITS:0]   sum;
  logic                 room;
  logic                 cur_used;

  assign sum      = {1'b0, nfp_r} + {1'b0, q_arg};
  assign room     = (count_r < CW'(MAX_BLOCKS)) && (sum < {1'b0, end_r});
  // take the next item only once the previous result has left
  assign q_take   = (state_r == S_IDLE) && q_valid && !ov_r;
  assign cur_used = used_r[idx_r[IW-1:0]];
  assign out_valid       = ov_r;
  assign out_status      = st_r;
  assign out_result_page = pg_r;

  // table memories, one read port registered
  always_ff @(posedge clk) begin
    if (q_take && q_action == ACT_ALLOC && room) begin
      base_mem[count_r[IW-1:0]] <= nfp_r;
      size_mem[count_r[IW-1:0]] <= q_arg;
    end
    rd_base_r <= base_mem[idx_r[IW-1:0]];
    rd_size_r <= size_mem[idx_r[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      used_r  <= '0;
      end_r   <= PAGE_BITS'(1048575);
      nfp_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      if (ov_r && !out_stall) ov_r <= 1'b0;
      if (cfg_valid) begin
        if (cfg_index_t'(cfg_index) == CFG_START) begin
          if (count_r == '0) nfp_r <= cfg_data;
        end else begin
          end_r <= cfg_data;
        end
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_take) begin
            act_r <= q_action;
            arg_r <= q_arg;
            idx_r <= '0;
            if (q_action == ACT_ALLOC && room) begin
              used_r[count_r[IW-1:0]] <= 1'b1;
              count_r <= count_r + 1'b1;
              nfp_r   <= sum[PAGE_BITS-1:0];
              st_r    <= ST_OK;
              pg_r    <= nfp_r;
              state_r <= S_OUT;
            end else begin
              state_r <= S_RD;
            end
          end
        end
        S_RD: begin
          // memory read under way
          if (idx_r >= count_r) begin
            st_r    <= (act_r == ACT_FREE) ? ST_NOT_ALLOCATED : ST_NO_SPACE;
            pg_r    <= '0;
            state_r <= S_OUT;
          end else begin
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          if (act_r == ACT_ALLOC && !cur_used && rd_size_r >= arg_r) begin
            used_r[idx_r[IW-1:0]] <= 1'b1;
            st_r    <= ST_OK;
            pg_r    <= rd_base_r;
            state_r <= S_OUT;
          end else if (act_r == ACT_FREE && rd_base_r == arg_r) begin
            used_r[idx_r[IW-1:0]] <= 1'b0;
            st_r    <= cur_used ? ST_OK : ST_DOUBLE_FREE;
            pg_r    <= '0;
            state_r <= S_OUT;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_RD;
          end
        end
        S_OUT: begin
          if (!ov_r || !out_stall) begin
            ov_r    <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// File: hdl/page_range_allocator.sv
// page_range_allocator: top level of the first-fit page range allocator.
// Depends on pra_pkg, pra_front and pra_back.
//
// Usage:
//   Input channel in_*: action 0 allocates in_request_pages, action 1 frees the
//   block whose base is in_free_page. An item is taken when in_valid is high
//   and in_stall low.
//   Output channel out_*: one item per request, status and result page, taken
//   when out_valid is high and out_stall low.
//   Config channel cfg_*: index 0 window start, 1 window end; write when idle.
// Sequence: an append goes from the front queue through S_IDLE and S_OUT to the
//   output register; a first-fit or free search visits the table entries in turn,
//   each with one memory read (S_RD) and one compare (S_CHK). The block table has
//   a single read port, hence one read per entry visited.
// Throughput: one item in the back end at a time; a two-item queue in front
//   keeps accepting while the back end searches.
// Reset: table empty, all blocks unused, window 0..1048575. No clearing pass.
// Stall: a result held by out_stall stays put; the back end takes no new item
//   until the output register is free, and the queue then fills.
module page_range_allocator #(
  parameter int unsigned MAX_BLOCKS = pra_pkg::MaxBlocksDefault,
  parameter int unsigned PAGE_BITS  = pra_pkg::PageBitsDefault
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_action,
  input  logic [PAGE_BITS-1:0] in_request_pages,
  input  logic [PAGE_BITS-1:0] in_free_page,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_status,
  output logic [PAGE_BITS-1:0] out_result_page,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [PAGE_BITS-1:0] cfg_data
);
  import pra_pkg::*;

  logic                 q_valid, q_take, q_action;
  logic [PAGE_BITS-1:0] q_arg;

  // config is always accepted
  assign cfg_ready = 1'b1;

  pra_front #(.PAGE_BITS(PAGE_BITS)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_action, .in_request_pages,
    .in_free_page, .q_valid, .q_take, .q_action, .q_arg
  );

  pra_back #(.MAX_BLOCKS(MAX_BLOCKS), .PAGE_BITS(PAGE_BITS)) u_back (
    .clk, .rst_n, .cfg_valid, .cfg_index, .cfg_data, .q_valid, .q_take,
    .q_action, .q_arg, .out_valid, .out_stall, .out_status, .out_result_page
  );
endmodule

// File: tb/sv/pra_checker.sv
// pra_checker: watches the request, grant and register channels of the page range
// allocator, predicts every grant and compares it field by field.
// Depends on pra_pkg.
module pra_checker #(
  parameter int unsigned MAX_BLOCKS = 64,
  parameter int unsigned PAGE_BITS  = 20
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 in_action,
  input  logic [PAGE_BITS-1:0] in_request_pages,
  input  logic [PAGE_BITS-1:0] in_free_page,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [1:0]           out_status,
  input  logic [PAGE_BITS-1:0] out_result_page,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [PAGE_BITS-1:0] cfg_data,
  output int                   fail_count
);
  import pra_pkg::*;

  typedef struct packed {
    status_t              status;
    logic [PAGE_BITS-1:0] page;
  } grant_t;

  logic [PAGE_BITS-1:0] win_start, win_end, next_page;
  logic [PAGE_BITS-1:0] blk_base [MAX_BLOCKS];
  logic [PAGE_BITS-1:0] blk_size [MAX_BLOCKS];
  logic                 blk_used [MAX_BLOCKS];
  int                   blk_count;
  int                   mismatches;
  grant_t               pending_grants [$];

  assign fail_count = mismatches + pending_grants.size();

  function automatic grant_t allocate_range(logic [PAGE_BITS-1:0] want);
    logic [PAGE_BITS:0] stop;
    grant_t g;
    stop = {1'b0, next_page} + {1'b0, want};
    g.status = ST_NO_SPACE;
    g.page = '0;
    if (blk_count < MAX_BLOCKS && stop < {1'b0, win_end}) begin
      blk_base[blk_count] = next_page;
      blk_size[blk_count] = want;
      blk_used[blk_count] = 1'b1;
      blk_count++;
      g.status = ST_OK;
      g.page = next_page;
      next_page = stop[PAGE_BITS-1:0];
      return g;
    end
    for (int i = 0; i < blk_count; i++) begin
      if (!blk_used[i] && blk_size[i] >= want) begin
        blk_used[i] = 1'b1;
        g.status = ST_OK;
        g.page = blk_base[i];
        return g;
      end
    end
    return g;
  endfunction

  function automatic grant_t release_range(logic [PAGE_BITS-1:0] base);
    grant_t g;
    g.status = ST_NOT_ALLOCATED;
    g.page = '0;
    for (int i = 0; i < blk_count; i++) begin
      if (blk_base[i] == base) begin
        if (!blk_used[i]) begin
          g.status = ST_DOUBLE_FREE;
        end else begin
          blk_used[i] = 1'b0;
          g.status = ST_OK;
        end
        return g;
      end
    end
    return g;
  endfunction

  always @(posedge clk) begin
    grant_t exp_g;
    if (!rst_n) begin
      win_start  = '0;
      win_end    = '1;
      next_page  = '0;
      blk_count  = 0;
      mismatches = 0;
      foreach (blk_used[i]) blk_used[i] = 1'b0;
      pending_grants.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_START) begin
          win_start = cfg_data;
          if (blk_count == 0) next_page = cfg_data;
        end else begin
          win_end = cfg_data;
        end
      end
      if (out_valid && !out_stall) begin
        if (pending_grants.size() == 0) begin
          $error("grant with no request outstanding: status %0d page %0d",
                 out_status, out_result_page);
          mismatches++;
        end else begin
          exp_g = pending_grants.pop_front();
          if (out_status !== exp_g.status) begin
            $error("status: expected %0d, actual %0d", exp_g.status, out_status);
            mismatches++;
          end
          if (out_result_page !== exp_g.page) begin
            $error("result_page: expected %0d, actual %0d", exp_g.page, out_result_page);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_action == ACT_ALLOC) pending_grants.push_back(allocate_range(in_request_pages));
        else pending_grants.push_back(release_range(in_free_page));
      end
    end
  end
endmodule

// File: tb/sv/tb_page_range_allocator.sv
// tb_page_range_allocator: stimulus and verdict for the page range allocator.
// Depends on pra_pkg, the allocator RTL and pra_checker.
module tb_page_range_allocator;
  import pra_pkg::*;

  localparam int unsigned MaxBlocks = 64;
  localparam int unsigned PageBits  = 20;
  localparam int          StallLimit = 5000;
  localparam int          LongHold   = 400;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  action_t             in_action = ACT_ALLOC;
  logic [PageBits-1:0] in_request_pages = '0;
  logic [PageBits-1:0] in_free_page = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [1:0]          out_status;
  logic [PageBits-1:0] out_result_page;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  cfg_index_t          cfg_index = CFG_START;
  logic [PageBits-1:0] cfg_data = '0;
  int                  fail_count;

  // stimulus bookkeeping, fed by watching the channels
  int                  sent_items = 0;
  int                  granted_items = 0;
  int                  quiet_cycles = 0;
  action_t             asked_actions [$];
  logic [PageBits-1:0] live_bases [$];
  bit                  idle_on = 1'b1;
  int                  hold_requests = 0;

  always #4 clk = ~clk;

  page_range_allocator #(.MAX_BLOCKS(MaxBlocks), .PAGE_BITS(PageBits)) u_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_action, .in_request_pages, .in_free_page,
    .out_valid, .out_stall, .out_status, .out_result_page,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  pra_checker #(.MAX_BLOCKS(MaxBlocks), .PAGE_BITS(PageBits)) u_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_action, .in_request_pages, .in_free_page,
    .out_valid, .out_stall, .out_status, .out_result_page,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .fail_count
  );

  // Track granted bases so that frees can target real blocks; advance the
  // counters and run the watchdog on cycles where nothing moves.
  always @(posedge clk) begin
    action_t act;
    bit moved;
    moved = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        granted_items++;
        act = asked_actions.pop_front();
        if (act == ACT_ALLOC && out_status == ST_OK) live_bases.push_back(out_result_page);
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        sent_items++;
        asked_actions.push_back(in_action);
      end
      if (cfg_valid && cfg_ready) moved = 1'b1;
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts while idling is on, and a long hold-off
  // whenever the stimulus asks for one, so the front queue fills up.
  initial begin
    int served;
    int burst;
    served = 0;
    forever begin
      @(negedge clk);
      if (served != hold_requests) begin
        served = hold_requests;
        out_stall = 1'b1;
        repeat (LongHold) @(negedge clk);
        out_stall = 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 16);
        out_stall = 1'b1;
        repeat (burst) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // Offer one item from a falling edge; return at the falling edge after it
  // was taken, with valid still high.
  task automatic send_item(action_t act, logic [PageBits-1:0] pages,
                           logic [PageBits-1:0] base);
    in_valid = 1'b1;
    in_action = act;
    in_request_pages = pages;
    in_free_page = base;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic sender_gap();
    int n;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 16);
      in_valid = 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Drop valid and hold until every outstanding grant has come back.
  task automatic drain();
    in_valid = 1'b0;
    while (granted_items != sent_items) @(negedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [PageBits-1:0] value);
    drain();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic random_item();
    int pick;
    int slot;
    logic [PageBits-1:0] pages;
    logic [PageBits-1:0] base;
    pick = $urandom_range(0, 99);
    pages = (pick < 6) ? PageBits'($urandom) : PageBits'($urandom_range(0, 120));
    base = PageBits'($urandom);
    if ($urandom_range(0, 1) == 0 || live_bases.size() == 0) begin
      send_item(ACT_ALLOC, pages, base);
    end else if ($urandom_range(0, 9) == 0) begin
      send_item(ACT_FREE, pages, base);
    end else begin
      slot = $urandom_range(0, live_bases.size() - 1);
      base = live_bases[slot];
      // mostly a real release; keep some bases around for double frees
      if ($urandom_range(0, 4) != 0) live_bases.delete(slot);
      send_item(ACT_FREE, pages, base);
    end
    sender_gap();
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // start after end: nothing can be appended on an empty table
    write_reg(CFG_END, '0);
    write_reg(CFG_START, 20'd5);
    send_item(ACT_ALLOC, 20'd0, '0);
    send_item(ACT_FREE, '0, 20'd5);
    // window pinned at the top page
    write_reg(CFG_START, '1);
    write_reg(CFG_END, '1);
    send_item(ACT_ALLOC, 20'd0, '1);
    send_item(ACT_ALLOC, '1, '0);
    // small window; zero-page block and a real block share a base
    write_reg(CFG_START, 20'd16);
    write_reg(CFG_END, 20'd4000);
    send_item(ACT_ALLOC, 20'd0, '0);
    send_item(ACT_ALLOC, '1, '1);
    send_item(ACT_ALLOC, 20'd10, '0);
    send_item(ACT_FREE, '1, 20'd16);
    send_item(ACT_FREE, '0, 20'd16);
    send_item(ACT_FREE, '0, 20'd999);
    send_item(ACT_ALLOC, 20'd0, '0);
    send_item(ACT_ALLOC, 20'd3970, '0);
    send_item(ACT_ALLOC, 20'd3900, '0);
    send_item(ACT_FREE, '0, 20'd26);
    send_item(ACT_ALLOC, 20'd5, '0);
    send_item(ACT_FREE, '0, '1);
    drain();

    // random phases over several windows; the last one runs without idling
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin write_reg(CFG_START, 20'd0); write_reg(CFG_END, 20'd6000); end
        1: begin write_reg(CFG_START, '1); write_reg(CFG_END, '0); end
        2: begin write_reg(CFG_END, '1); end
        3: begin write_reg(CFG_START, 20'd0); write_reg(CFG_END, 20'd2000); end
        default: begin write_reg(CFG_END, '1); idle_on = 1'b0; end
      endcase
      if (phase == 1 || phase == 3) hold_requests++;
      for (int n = 0; n < 240; n++) random_item();
      drain();
    end

    in_valid = 1'b0;
    repeat (2 * MaxBlocks + 20) @(negedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
